// File: rtl/bf5_pkg.sv
// Shared types, constants and the range-weight table of the 5x5 bilateral filter.
package bf5_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int WINDOW           = 5;
    localparam int HALF_WIN         = WINDOW / 2;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
    localparam int PIX_W            = 8;
    localparam int CFG_DATA_W       = 17;
    localparam int CFG_INDEX_W      = 3;
    localparam int HEIGHT_W         = 16;
    localparam int SUM_W            = 22;
    localparam int ACC_W            = 30;
    localparam int NUM_CLASSES      = 6;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_D0   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_D1   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_D2   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_D4   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_D5   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_D8   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic shift;
        logic mac_start;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic adv;
        logic produce;
        logic mac_done;
        logic div_done;
        logic out_free;
    } status_t;

    typedef logic [WEIGHT_W-1:0] range_rom_t [0:255];

    // Unsigned 64-bit quotient by shift and subtract, used only while building the table.
    function automatic logic [63:0] table_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-d*d/2000) in fixed point: a truncated series followed by six squarings.
    function automatic range_rom_t build_range_rom();
        range_rom_t rom;
        logic [63:0] d2;
        logic [63:0] term;
        logic [63:0] a;
        longint      acc;
        for (int d = 0; d < 256; d++) begin
            d2   = 64'(d) * 64'(d);
            term = 64'd1 << 30;
            acc  = 0;
            for (int k = 0; k < 14; k++) begin
                if ((k % 2) == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
                term = table_div(term * d2, 64'd128000 * 64'(k + 1));
            end
            a = (acc < 0) ? 64'd0 : 64'(acc);
            for (int k = 0; k < 6; k++) begin
                a = (a * a + (64'd1 << 29)) >> 30;
            end
            rom[d] = WEIGHT_W'((a + (64'd1 << (29 - WEIGHT_FRAC_BITS)))
                               >> (30 - WEIGHT_FRAC_BITS));
        end
        return rom;
    endfunction

    localparam range_rom_t RANGE_ROM = build_range_rom();

    // Distance class of a tap from its row and column in the window.
    function automatic logic [2:0] spatial_class(input logic [2:0] tr, input logic [2:0] tc);
        logic [1:0] ar;
        logic [1:0] ac;
        logic [1:0] lo;
        logic [1:0] hi;
        ar = (tr >= 3'd2) ? 2'(tr - 3'd2) : 2'(3'd2 - tr);
        ac = (tc >= 3'd2) ? 2'(tc - 3'd2) : 2'(3'd2 - tc);
        lo = (ar < ac) ? ar : ac;
        hi = (ar < ac) ? ac : ar;
        if (hi == 2'd0) return 3'd0;
        else if (hi == 2'd1) return (lo == 2'd0) ? 3'd1 : 3'd2;
        else if (lo == 2'd0) return 3'd3;
        else if (lo == 2'd1) return 3'd4;
        else return 3'd5;
    endfunction

endpackage

// File: rtl/bf5_ctrl.sv
// Sequencer of the 5x5 bilateral filter: steps one item through read, shift, MAC, divide and output.
module bf5_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output bf5_pkg::cmd_t     cmd,
    input  bf5_pkg::status_t  st
);
    import bf5_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_READ;
            ST_READ:  state_next = st.adv ? ST_SHIFT : ST_IDLE;
            ST_SHIFT: state_next = st.produce ? ST_MAC : ST_IDLE;
            ST_MAC:   if (st.mac_done) state_next = ST_DIV;
            ST_DIV:   if (st.div_done) state_next = ST_OUT;
            ST_OUT:   if (st.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_READ:  ;
            ST_SHIFT:
            begin
                cmd.shift     = 1'b1;
                cmd.mac_start = st.produce;
            end
            ST_MAC:   cmd.div_start = st.mac_done;
            ST_DIV:   ;
            ST_OUT:   cmd.load_out = st.out_free;
            default:  ;
        endcase
    end

endmodule

// File: rtl/bf5_datapath.sv
// Datapath of the 5x5 bilateral filter: registers, line store, window, MAC, divider, output.
module bf5_datapath #(
    parameter int MAX_WIDTH = bf5_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bf5_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bf5_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [bf5_pkg::PIX_W-1:0]         in_pixel,
    input  logic                              in_frame_start,
    input  logic                              in_drain,
    input  bf5_pkg::cmd_t                     cmd,
    output bf5_pkg::status_t                  st,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bf5_pkg::PIX_W-1:0]         out_pixel,
    output logic                              out_last
);
    import bf5_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CSW = CW + 2;
    localparam int RSW = HEIGHT_W + 3;
    localparam int RW  = HEIGHT_W + 1;

    // Configuration registers.
    logic [10:0]           img_w_reg;
    logic [HEIGHT_W-1:0]   img_h_reg;
    logic [WEIGHT_W-1:0]   spw_reg [NUM_CLASSES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg  <= 11'd512;
            img_h_reg  <= 16'd512;
            spw_reg[0] <= 17'd65536;
            spw_reg[1] <= 17'd51040;
            spw_reg[2] <= 17'd39750;
            spw_reg[3] <= 17'd24109;
            spw_reg[4] <= 17'd18776;
            spw_reg[5] <= 17'd8869;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  img_w_reg  <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT: img_h_reg  <= cfg_data[HEIGHT_W-1:0];
                CFG_SPATIAL_D0:   spw_reg[0] <= cfg_data;
                CFG_SPATIAL_D1:   spw_reg[1] <= cfg_data;
                CFG_SPATIAL_D2:   spw_reg[2] <= cfg_data;
                CFG_SPATIAL_D4:   spw_reg[3] <= cfg_data;
                CFG_SPATIAL_D5:   spw_reg[4] <= cfg_data;
                CFG_SPATIAL_D8:   spw_reg[5] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Frame geometry and position counters.
    logic [CW-1:0]        fw_reg;
    logic [HEIGHT_W-1:0]  fh_reg;
    logic                 active_reg;
    logic [CW-1:0]        icol_reg;
    logic [RW-1:0]        irow_reg;
    logic [CW-1:0]        ocol_reg;
    logic [HEIGHT_W-1:0]  orow_reg;
    logic                 adv_reg;
    logic [PIX_W-1:0]     pix_reg;

    logic                 fs;
    logic [CW-1:0]        fw_clamp;
    logic [HEIGHT_W-1:0]  fh_clamp;
    logic                 active_n;
    logic [HEIGHT_W-1:0]  fh_n;
    logic [RW-1:0]        irow_n;
    logic [HEIGHT_W-1:0]  orow_n;
    logic                 adv;
    logic                 produce;
    logic                 last;

    always_comb
    begin
        fs = !in_drain && in_frame_start;
        if (img_w_reg < 11'd3) fw_clamp = CW'(3);
        else if (32'(img_w_reg) > MAX_WIDTH) fw_clamp = CW'(MAX_WIDTH);
        else fw_clamp = CW'(img_w_reg);
        fh_clamp = (img_h_reg < 16'd3) ? 16'd3 : img_h_reg;
        active_n = fs ? 1'b1 : active_reg;
        fh_n     = fs ? fh_clamp : fh_reg;
        irow_n   = fs ? '0 : irow_reg;
        orow_n   = fs ? '0 : orow_reg;
        if (in_drain)
            adv = active_n && (irow_n >= RW'(fh_n)) && (orow_n < fh_n);
        else
            adv = active_n && (irow_n < RW'(fh_n));
        produce = ((irow_reg > RW'(2)) || ((irow_reg == RW'(2)) && (icol_reg >= CW'(2))))
                  && (orow_reg < fh_reg);
        last = (orow_reg == fh_reg - 16'd1) && (ocol_reg == fw_reg - CW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= CW'(3);
            fh_reg     <= 16'd3;
            active_reg <= 1'b0;
            icol_reg   <= '0;
            irow_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            adv_reg    <= 1'b0;
            pix_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                adv_reg <= adv;
                pix_reg <= in_drain ? '0 : in_pixel;
                if (fs)
                begin
                    fw_reg     <= fw_clamp;
                    fh_reg     <= fh_clamp;
                    active_reg <= 1'b1;
                    icol_reg   <= '0;
                    irow_reg   <= '0;
                    ocol_reg   <= '0;
                    orow_reg   <= '0;
                end
            end
            if (cmd.shift)
            begin
                if (icol_reg + CW'(1) >= fw_reg)
                begin
                    icol_reg <= '0;
                    irow_reg <= irow_reg + RW'(1);
                end
                else
                begin
                    icol_reg <= icol_reg + CW'(1);
                end
            end
            if (cmd.load_out)
            begin
                if (ocol_reg + CW'(1) >= fw_reg)
                begin
                    ocol_reg <= '0;
                    orow_reg <= orow_reg + 16'd1;
                end
                else
                begin
                    ocol_reg <= ocol_reg + CW'(1);
                end
                if (last) active_reg <= 1'b0;
            end
        end
    end

    assign st.adv     = adv_reg;
    assign st.produce = produce;

    // Line store: four earlier rows per column, newest in the low byte.
    logic [31:0] store_mem [MAX_WIDTH];
    logic [31:0] store_rd_reg;

    always_ff @(posedge clk)
    begin
        store_rd_reg <= store_mem[icol_reg[AW-1:0]];
        if (cmd.shift) store_mem[icol_reg[AW-1:0]] <= {store_rd_reg[23:0], pix_reg};
    end

    // 5x5 window, column 4 is the newest.
    logic [PIX_W-1:0] win_reg [WINDOW][WINDOW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < WINDOW; r++)
                for (int c = 0; c < WINDOW; c++)
                    win_reg[r][c] <= '0;
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < WINDOW; r++)
                for (int c = 0; c < WINDOW - 1; c++)
                    win_reg[r][c] <= win_reg[r][c + 1];
            win_reg[4][4] <= pix_reg;
            win_reg[3][4] <= store_rd_reg[7:0];
            win_reg[2][4] <= store_rd_reg[15:8];
            win_reg[1][4] <= store_rd_reg[23:16];
            win_reg[0][4] <= store_rd_reg[31:24];
        end
    end

    // Tap selection with mirrored borders.
    logic [2:0]              tr_reg;
    logic [2:0]              tc_reg;
    logic                    issue_reg;
    logic signed [RSW-1:0]   vr;
    logic signed [RSW-1:0]   mr;
    logic signed [RSW-1:0]   wr_full;
    logic signed [RSW-1:0]   fh_s;
    logic signed [RSW-1:0]   orow_s;
    logic signed [CSW-1:0]   vc;
    logic signed [CSW-1:0]   mc;
    logic signed [CSW-1:0]   wc_full;
    logic signed [CSW-1:0]   fw_s;
    logic signed [CSW-1:0]   ocol_s;
    logic [2:0]              wr;
    logic [2:0]              wc;
    logic [PIX_W-1:0]        tap_pix;
    logic [PIX_W-1:0]        centre;
    logic [PIX_W-1:0]        diff;
    logic [WEIGHT_W-1:0]     spw;
    logic [WEIGHT_W-1:0]     spw_sat;
    logic [2*WEIGHT_W-1:0]   prod;

    always_comb
    begin
        fh_s    = $signed(RSW'(fh_reg));
        orow_s  = $signed(RSW'(orow_reg));
        vr      = orow_s + $signed(RSW'(tr_reg)) - RSW'(2);
        if (vr < 0) mr = -vr;
        else if (vr >= fh_s) mr = ((fh_s - RSW'(1)) <<< 1) - vr;
        else mr = vr;
        wr_full = mr - orow_s + RSW'(2);
        wr      = wr_full[2:0];

        fw_s    = $signed(CSW'(fw_reg));
        ocol_s  = $signed(CSW'(ocol_reg));
        vc      = ocol_s + $signed(CSW'(tc_reg)) - CSW'(2);
        if (vc < 0) mc = -vc;
        else if (vc >= fw_s) mc = ((fw_s - CSW'(1)) <<< 1) - vc;
        else mc = vc;
        wc_full = mc - ocol_s + CSW'(2);
        wc      = wc_full[2:0];

        tap_pix = win_reg[wr][wc];
        centre  = win_reg[HALF_WIN][HALF_WIN];
        diff    = (tap_pix > centre) ? tap_pix - centre : centre - tap_pix;
        spw     = spw_reg[spatial_class(tr_reg, tc_reg)];
        spw_sat = (spw > WEIGHT_ONE) ? WEIGHT_ONE : spw;
        prod    = spw_sat * RANGE_ROM[diff];
    end

    // Multiply-accumulate: one tap issued per cycle, weight product registered.
    logic [2*WEIGHT_W-1:0]   prod_reg;
    logic [PIX_W-1:0]        ppix_reg;
    logic                    pvalid_reg;
    logic [SUM_W-1:0]        ws_reg;
    logic [ACC_W-1:0]        wi_reg;
    logic [2*WEIGHT_W-1:0]   rounded;
    logic [WEIGHT_W-1:0]     tap_w;

    always_comb
    begin
        rounded = prod_reg + (2*WEIGHT_W)'(1 << (WEIGHT_FRAC_BITS - 1));
        tap_w   = rounded[WEIGHT_FRAC_BITS +: WEIGHT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tr_reg     <= '0;
            tc_reg     <= '0;
            issue_reg  <= 1'b0;
            pvalid_reg <= 1'b0;
            ws_reg     <= '0;
            wi_reg     <= '0;
        end
        else if (cmd.mac_start)
        begin
            tr_reg     <= '0;
            tc_reg     <= '0;
            issue_reg  <= 1'b1;
            pvalid_reg <= 1'b0;
            ws_reg     <= '0;
            wi_reg     <= '0;
        end
        else
        begin
            pvalid_reg <= issue_reg;
            if (issue_reg)
            begin
                if (tc_reg == 3'(WINDOW - 1))
                begin
                    tc_reg <= '0;
                    if (tr_reg == 3'(WINDOW - 1)) issue_reg <= 1'b0;
                    else tr_reg <= tr_reg + 3'd1;
                end
                else
                begin
                    tc_reg <= tc_reg + 3'd1;
                end
            end
            if (pvalid_reg)
            begin
                ws_reg <= ws_reg + SUM_W'(tap_w);
                wi_reg <= wi_reg + ACC_W'(tap_w) * ACC_W'(ppix_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        ppix_reg <= tap_pix;
    end

    assign st.mac_done = !issue_reg && !pvalid_reg;

    // Restoring divider; the quotient always fits in eight bits.
    logic [ACC_W-1:0] rem_reg;
    logic [PIX_W-1:0] q_reg;
    logic [3:0]       dcnt_reg;
    logic [2:0]       dbit;
    logic [ACC_W-1:0] trial;

    always_comb
    begin
        dbit  = 3'(dcnt_reg - 4'd1);
        trial = ACC_W'(ws_reg) << dbit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= 4'd8;
            rem_reg  <= wi_reg;
            q_reg    <= '0;
        end
        else if (dcnt_reg != 4'd0)
        begin
            dcnt_reg <= dcnt_reg - 4'd1;
            if (rem_reg >= trial)
            begin
                rem_reg     <= rem_reg - trial;
                q_reg[dbit] <= 1'b1;
            end
        end
    end

    assign st.div_done = (dcnt_reg == 4'd0);

    // Output register.
    logic             ovalid_reg;
    logic [PIX_W-1:0] opix_reg;
    logic             olast_reg;

    assign st.out_free = !ovalid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            opix_reg   <= '0;
            olast_reg  <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            ovalid_reg <= 1'b1;
            opix_reg   <= (ws_reg == '0) ? centre : q_reg;
            olast_reg  <= last;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_pixel = opix_reg;
    assign out_last  = olast_reg;

endmodule

// File: rtl/bilateral_filter_5x5_top.sv
// Top level of the streaming 5x5 bilateral filter for 8-bit grayscale frames.
//
// Pixels enter in raster order on the s_ stream and filtered pixels leave in raster
// order on the m_ stream, delayed by two rows and two pixels; m_tlast marks the last
// pixel of the frame. Set frame_start (s_tuser bit 0) on the first pixel of a frame;
// the width and height registers are taken at that moment, the spatial weights act at
// once. After the last pixel send 2*width+2 drain items (s_tuser bit 1) to flush the
// frame. Borders are mirrored without repeating the edge pixel. One item at a time is
// processed: an item that moves the window but yields no output passes the read and
// shift states, an item that is ignored only the read state, and one that yields an
// output also passes the single multiply-accumulate unit that walks the 25 taps, the
// 8-step serial divider and a wait for a free output register. A new item is taken
// while a finished output still waits in the output register. Weights are Q16.
module bilateral_filter_5x5_top #(
    parameter int MAX_WIDTH = bf5_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [bf5_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bf5_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // pixel
    input  logic [1:0]                        s_tuser,   // frame_start, drain
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // filtered_pixel
    output logic                              m_tlast    // last_of_frame
);
    import bf5_pkg::*;

    cmd_t    cmd;
    status_t st;

    bf5_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    bf5_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_pixel       (s_tdata),
        .in_frame_start (s_tuser[0]),
        .in_drain       (s_tuser[1]),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_pixel      (m_tdata),
        .out_last       (m_tlast)
    );

endmodule

// File: verif/testbench.sv
// Self-checking testbench of the streaming 5x5 bilateral filter.
module testbench;
    import bf5_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic                   m_tlast;

    bilateral_filter_5x5_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } filtered_t;

    // One row of the directed table: a frame of a given size, a pixel pattern and a weight setting.
    typedef struct {
        int width;
        int height;
        int pattern;   // 0 flat zero, 1 flat 255, 2 checker 0/255, 3 random
        int weights;   // 0 reset values, 1 all full scale, 2 all zero, 3 above full scale
    } frame_row_t;

    // Golden copies of the block's registers and state.
    logic [10:0] gold_width_reg;
    logic [15:0] gold_height_reg;
    logic [16:0] gold_spatial [NUM_CLASSES];
    logic [31:0] gold_lines [1024];
    logic [7:0]  gold_win [5][5];
    int unsigned in_col, in_row, out_col, out_row, fw, fh;
    bit          active;
    logic [16:0] range_w [256];

    filtered_t expected_pixels [$];
    int        errors;
    int        outputs_seen;
    int        frames_done;
    bit        tail_quiet;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("bilateral_filter_5x5_top: mismatch");
        $finish;
    end

    // Range table built independently: alternating series, then six squarings.
    task automatic make_range_table();
        longint unsigned d2;
        longint unsigned term;
        longint unsigned a;
        longint          acc;
        for (int d = 0; d < 256; d++)
        begin
            d2   = d * d;
            term = 64'd1 << 30;
            acc  = 0;
            for (int k = 0; k < 14; k++)
            begin
                acc  = (k & 1) ? acc - longint'(term) : acc + longint'(term);
                term = term * d2 / (64'd128000 * (k + 1));
            end
            a = (acc < 0) ? 0 : acc;
            repeat (6) a = (a * a + (64'd1 << 29)) >> 30;
            range_w[d] = 17'((a + (64'd1 << 13)) >> 14);
        end
    endtask

    function automatic int reflect(int v, int n);
        if (v < 0) return -v;
        if (v >= n) return 2 * (n - 1) - v;
        return v;
    endfunction

    function automatic longint unsigned class_weight(int d2);
        longint unsigned s;
        case (d2)
            0: s = gold_spatial[0];
            1: s = gold_spatial[1];
            2: s = gold_spatial[2];
            4: s = gold_spatial[3];
            5: s = gold_spatial[4];
            default: s = gold_spatial[5];
        endcase
        return (s > 65536) ? 65536 : s;
    endfunction

    function automatic logic [7:0] filter_pixel(int orow, int ocol);
        longint unsigned wsum;
        longint unsigned isum;
        longint unsigned w;
        int              wr;
        int              wc;
        int              p;
        int              ctr;
        int              diff;
        ctr  = gold_win[2][2];
        wsum = 0;
        isum = 0;
        for (int dr = -2; dr <= 2; dr++)
        begin
            wr = reflect(orow + dr, fh) - orow + 2;
            for (int dc = -2; dc <= 2; dc++)
            begin
                wc   = reflect(ocol + dc, fw) - ocol + 2;
                p    = gold_win[wr][wc];
                diff = (p > ctr) ? p - ctr : ctr - p;
                w    = (class_weight(dr * dr + dc * dc) * range_w[diff] + 32768) >> 16;
                wsum += w;
                isum += w * p;
            end
        end
        if (wsum == 0) return 8'(ctr);
        return 8'(isum / wsum);
    endfunction

    // Advances the golden state by one accepted item and queues any output.
    task automatic predict_filter(logic [7:0] pix_in, logic fs, logic drn);
        logic [31:0] col;
        logic [7:0]  pix;
        int unsigned pr;
        int unsigned pc;
        int unsigned w;
        int unsigned h;
        filtered_t   res;
        pix = pix_in;
        if (!drn && fs)
        begin
            w  = gold_width_reg;
            h  = gold_height_reg;
            fw = (w < 3) ? 3 : (w > 1024) ? 1024 : w;
            fh = (h < 3) ? 3 : h;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            active = 1'b1;
        end
        if (!active) return;
        if (!drn && in_row >= fh) return;
        if (drn && (in_row < fh || out_row >= fh)) return;
        if (drn) pix = 8'd0;
        col = gold_lines[in_col];
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 4; c++)
                gold_win[r][c] = gold_win[r][c + 1];
        gold_win[4][4] = pix;
        gold_win[3][4] = col[7:0];
        gold_win[2][4] = col[15:8];
        gold_win[1][4] = col[23:16];
        gold_win[0][4] = col[31:24];
        gold_lines[in_col] = {col[23:0], pix};
        pr = in_row;
        pc = in_col;
        in_col++;
        if (in_col >= fw)
        begin
            in_col = 0;
            in_row++;
        end
        if ((pr > 2 || (pr == 2 && pc >= 2)) && out_row < fh)
        begin
            res.last = (out_row == fh - 1) && (out_col == fw - 1);
            res.pix  = filter_pixel(out_row, out_col);
            expected_pixels.push_back(res);
            out_col++;
            if (out_col >= fw)
            begin
                out_col = 0;
                out_row++;
            end
            if (res.last) active = 1'b0;
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  gold_width_reg  = val[10:0];
            CFG_IMAGE_HEIGHT: gold_height_reg = val[15:0];
            default:          gold_spatial[idx - CFG_SPATIAL_D0] = val;
        endcase
    endtask

    // Waits until every queued output has arrived, then lets the block settle.
    task automatic wait_quiet();
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Drives at the falling edge; the item is taken at the first rising edge with ready.
    task automatic send_item(logic [7:0] pix, logic fs, logic drn);
        if (!tail_quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pix;
        s_tuser  = {drn, fs};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_filter(pix, fs, drn);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic set_weights(int mode);
        int                     vals [6];
        logic [CFG_INDEX_W-1:0] idx;
        vals = '{65536, 51040, 39750, 24109, 18776, 8869};
        for (int i = 0; i < 6; i++)
        begin
            idx = CFG_INDEX_W'(CFG_SPATIAL_D0 + i);
            case (mode)
                0: write_reg(idx, 17'(vals[i]));
                1: write_reg(idx, 17'(65536));
                2: write_reg(idx, 17'(0));
                3: write_reg(idx, 17'h1FFFF);
                default: write_reg(idx, 17'($urandom_range(0, 131071)));
            endcase
        end
    endtask

    // Sends one whole frame followed by its drain items. With noisy set it adds noise:
    // stray pixels, early drains, and in rare cases an abandoned frame.
    task automatic run_frame(int w, int h, int pattern, bit noisy);
        int         n;
        logic [7:0] p;
        int         cut;
        write_reg(CFG_IMAGE_WIDTH, 17'(w));
        write_reg(CFG_IMAGE_HEIGHT, 17'(h));
        n   = w * h;
        cut = (noisy && $urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < cut; i++)
        begin
            case (pattern)
                0: p = 8'd0;
                1: p = 8'd255;
                2: p = (((i % w) + (i / w)) & 1) ? 8'd255 : 8'd0;
                default: p = 8'($urandom);
            endcase
            if (noisy && i != 0 && $urandom_range(0, 30) == 0)
                send_item(8'($urandom), 1'b0, 1'b1);
            send_item(p, i == 0, 1'b0);
        end
        if (cut < n)
        begin
            // Abandoned frame: the next frame_start drops its pending outputs.
            wait_quiet();
            return;
        end
        if (noisy) send_item(8'($urandom), 1'b0, 1'b0);
        for (int i = 0; i < 2 * w + 2; i++)
            send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        if (noisy) send_item(8'($urandom), 1'b1, 1'b1);
        wait_quiet();
        frames_done++;
    endtask

    // Output side: random stalls, field by field comparison.
    initial
    begin
        filtered_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!tail_quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                outputs_seen++;
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected output pixel %0d", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want.pix)
                    begin
                        $error("filtered_pixel expected %0d actual %0d", want.pix, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_frame expected %0d actual %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    frame_row_t directed [6] = '{
        '{3, 3, 0, 0}, '{3, 3, 1, 1}, '{4, 3, 2, 2},
        '{5, 4, 3, 3}, '{3, 5, 2, 0}, '{6, 3, 3, 0}
    };

    initial
    begin
        int w;
        int h;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        errors = 0; outputs_seen = 0; frames_done = 0; tail_quiet = 0;
        make_range_table();
        gold_width_reg  = 11'd512;
        gold_height_reg = 16'd512;
        gold_spatial    = '{65536, 51040, 39750, 24109, 18776, 8869};
        for (int i = 0; i < 1024; i++) gold_lines[i] = '0;
        for (int r = 0; r < 5; r++) for (int c = 0; c < 5; c++) gold_win[r][c] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; fw = 3; fh = 3; active = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Before any frame: stray pixels and drains give nothing.
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'h55, 1'b1, 1'b1);

        // Directed frames; flat frames must come back unchanged.
        foreach (directed[i])
        begin
            set_weights(directed[i].weights);
            if (directed[i].pattern < 2)
            begin
                run_frame(directed[i].width, directed[i].height, directed[i].pattern, 0);
            end
            else
                run_frame(directed[i].width, directed[i].height, directed[i].pattern, 0);
        end

        // Width and height values outside the legal span are clamped.
        write_reg(CFG_SPATIAL_D0, 17'd65536);
        run_frame(3, 3, 3, 0);
        write_reg(CFG_IMAGE_WIDTH, 17'd1);
        write_reg(CFG_IMAGE_HEIGHT, 17'd0);
        for (int i = 0; i < 9; i++) send_item(8'($urandom), i == 0, 1'b0);
        for (int i = 0; i < 8; i++) send_item(8'd0, 1'b0, 1'b1);
        wait_quiet();

        // Random frames, mostly small, at least one 128 wide.
        while (frames_done < 27)
        begin
            if ($urandom_range(0, 3) == 0) set_weights(4);
            if (frames_done == 20)
            begin
                w = 128;
                h = 3;
            end
            else
            begin
                w = $urandom_range(3, 9);
                h = $urandom_range(3, 6);
            end
            if (frames_done >= 24) tail_quiet = 1;
            run_frame(w, h, 3, frames_done < 24);
        end

        wait_quiet();
        $display("Covered %0d frames and %0d filtered pixels, sizes from 3x3 up to 128 wide,",
                 frames_done, outputs_seen);
        $display("with zero, full-scale and random spatial weights plus stray and drain items.");
        if (errors == 0)
            $display("bilateral_filter_5x5_top: match");
        else
            $display("bilateral_filter_5x5_top: mismatch");
        $finish;
    end

endmodule

// File: bilateral_filter_5x5_top.f
rtl/bf5_pkg.sv
rtl/bf5_ctrl.sv
rtl/bf5_datapath.sv
rtl/bilateral_filter_5x5_top.sv
verif/testbench.sv
